// ----- design/range_add_rightmost_zero_tree_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the range-add / rightmost-zero tree.
// These macros assume a clock named clk and an active-low reset named arst_n.
// ---------------------------------------------------------------------------
`ifndef RANGE_ADD_RIGHTMOST_ZERO_TREE_DEFINES_SVH
`define RANGE_ADD_RIGHTMOST_ZERO_TREE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define RAZT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define RAZT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

// ----- design/razt_pkg.sv -----
// ---------------------------------------------------------------------------
// razt_pkg
// Shared constants and the command/status types between controller and
// datapath of the range-add / rightmost-zero tree.
// ---------------------------------------------------------------------------
package razt_pkg;

	// Default number of leaf positions.
	localparam int unsigned LEAVES_DEF = 1024;

	// Fixed field widths.
	localparam int VAL_W   = 16;
	localparam int POS_W   = 10;
	localparam int DELTA_W = 12;
	localparam int SIZE_W  = 11;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_START,
		OP_RD_NODE,
		OP_WR_NODE,
		OP_RD_LCH,
		OP_WR_LCH,
		OP_RD_RCH,
		OP_WR_RCH,
		OP_MERGE,
		OP_PUSH_LEFT,
		OP_PUSH_RIGHT,
		OP_LEFT_TAIL,
		OP_POP,
		OP_SET_RES,
		OP_SET_NONE
	} dp_op_t;

	// Where a suspended node resumes after its child call returns.
	typedef enum logic [1:0] {
		RET_ADD_L,
		RET_ADD_R,
		RET_FIND_R
	} ret_t;

	typedef struct packed {
		dp_op_t op;
		ret_t   ret;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_find;
		logic full;
		logic disjoint;
		logic leaf;
		logic prune;
		logic tnz;
		logic stk_empty;
		ret_t ret;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- design/razt_dp.sv -----
// ---------------------------------------------------------------------------
// razt_dp
// Datapath: node memory, current frame, call stack, size register and the
// result register. Executes one operation per cycle as commanded.
// ---------------------------------------------------------------------------
`include "range_add_rightmost_zero_tree_defines.svh"

module razt_dp #(
	parameter int unsigned LEAVES = razt_pkg::LEAVES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  razt_pkg::dp_cmd_t     cmd,
	output razt_pkg::dp_stat_t    stat,
	input  logic                  in_cmd,
	input  logic [31:0]           in_data,
	input  logic                  cfg_valid,
	input  logic [15:0]           cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic                  out_found,
	output logic [razt_pkg::POS_W-1:0] out_pos
);

	localparam int IW    = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int CW    = (IW > razt_pkg::POS_W) ? IW : razt_pkg::POS_W;
	localparam int AW    = $clog2(4 * LEAVES);
	localparam int DEPTH = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int PW    = $clog2(DEPTH + 1);
	localparam int IX    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int VW    = razt_pkg::VAL_W;

	typedef struct packed {
		logic [VW-1:0] mn;
		logic [VW-1:0] mx;
		logic [VW-1:0] pd;
	} node_t;

	node_t mem [4*LEAVES];
	node_t rd_q, hold_q, wdata;
	logic [AW-1:0] addr, clr_q, k_q, k2, k2p1;
	logic wen, ren;

	logic [razt_pkg::SIZE_W-1:0] size_q;
	logic cmd_q;
	logic [razt_pkg::POS_W-1:0] lo_q, hi_q;
	logic [VW-1:0] d_q, t_q, t_now, new_mn, new_mx;
	logic [IW-1:0] s_q, e_q, mid, last;
	razt_pkg::ret_t ret_q;
	logic prune_q;

	logic [AW-1:0] stk_k_q [2**IX];
	logic [IW-1:0] stk_s_q [2**IX];
	logic [IW-1:0] stk_e_q [2**IX];
	razt_pkg::ret_t stk_r_q [2**IX];
	logic [PW-1:0] sp_q;
	logic [IX-1:0] top;

	logic out_valid_q, found_q;
	logic [razt_pkg::POS_W-1:0] pos_q;

	logic [CW-1:0] sx, ex, lox, hix;
	logic full, disj, prune_now;
	logic [31:0] nsz;

	// Effective size, clamped to one and to the leaf count.
	always_comb begin
		nsz = 32'(size_q);
		if (nsz == 32'd0) begin
			nsz = 32'd1;
		end
		if (nsz > 32'(LEAVES)) begin
			nsz = 32'(LEAVES);
		end
		last = IW'(nsz - 32'd1);
	end

	// Range relations of the current node and the pushed-down add.
	always_comb begin
		sx   = CW'(s_q);
		ex   = CW'(e_q);
		lox  = CW'(lo_q);
		hix  = CW'(hi_q);
		full = (lox <= sx) && (ex <= hix);
		disj = (hix < sx) || (ex < lox);
		mid  = IW'(({1'b0, s_q} + {1'b0, e_q}) >> 1);
		k2   = {k_q[AW-2:0], 1'b0};
		k2p1 = {k_q[AW-2:0], 1'b1};
		t_now  = rd_q.pd + ((!cmd_q && full) ? d_q : '0);
		new_mn = rd_q.mn + t_now;
		new_mx = rd_q.mx + t_now;
		prune_now = (ex < lox) || ($signed(new_mn) > $signed(VW'(0)))
			|| ($signed(new_mx) < $signed(VW'(0)));
		top = IX'(sp_q - PW'(1));
	end

	// Memory address, write data and enables per operation.
	always_comb begin
		addr  = k_q;
		wen   = 1'b0;
		ren   = 1'b0;
		wdata = '0;
		case (cmd.op)
			razt_pkg::OP_CLR: begin
				addr = clr_q;
				wen  = 1'b1;
			end
			razt_pkg::OP_RD_NODE: begin
				ren = 1'b1;
			end
			razt_pkg::OP_WR_NODE: begin
				wen   = 1'b1;
				wdata = '{mn: new_mn, mx: new_mx, pd: '0};
			end
			razt_pkg::OP_RD_LCH: begin
				addr = k2;
				ren  = 1'b1;
			end
			razt_pkg::OP_RD_RCH: begin
				addr = k2p1;
				ren  = 1'b1;
			end
			razt_pkg::OP_WR_LCH, razt_pkg::OP_WR_RCH: begin
				addr  = (cmd.op == razt_pkg::OP_WR_LCH) ? k2 : k2p1;
				wen   = 1'b1;
				wdata = '{mn: rd_q.mn, mx: rd_q.mx, pd: rd_q.pd + t_q};
			end
			razt_pkg::OP_MERGE: begin
				wen      = 1'b1;
				wdata.mn = ($signed(hold_q.mn) < $signed(rd_q.mn)) ? hold_q.mn : rd_q.mn;
				wdata.mx = ($signed(hold_q.mx) > $signed(rd_q.mx)) ? hold_q.mx : rd_q.mx;
				wdata.pd = '0;
			end
			default: begin
			end
		endcase
	end

	// Node memory with registered read data.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[addr] <= wdata;
		end
		if (ren) begin
			rd_q <= mem[addr];
		end
	end

	// Payload registers: fields, frame, stack, work values.
	always_ff @(posedge clk) begin
		case (cmd.op)
			razt_pkg::OP_START: begin
				cmd_q <= in_cmd;
				lo_q  <= in_data[9:0];
				hi_q  <= in_data[19:10];
				d_q   <= VW'($signed(in_data[31:20]));
				k_q   <= AW'(1);
				s_q   <= '0;
				e_q   <= last;
			end
			razt_pkg::OP_WR_NODE: begin
				t_q     <= t_now;
				prune_q <= prune_now;
			end
			razt_pkg::OP_RD_RCH: begin
				hold_q <= rd_q;
			end
			razt_pkg::OP_PUSH_LEFT: begin
				stk_k_q[IX'(sp_q)] <= k_q;
				stk_s_q[IX'(sp_q)] <= s_q;
				stk_e_q[IX'(sp_q)] <= e_q;
				stk_r_q[IX'(sp_q)] <= cmd.ret;
				k_q <= k2;
				e_q <= mid;
			end
			razt_pkg::OP_PUSH_RIGHT: begin
				stk_k_q[IX'(sp_q)] <= k_q;
				stk_s_q[IX'(sp_q)] <= s_q;
				stk_e_q[IX'(sp_q)] <= e_q;
				stk_r_q[IX'(sp_q)] <= cmd.ret;
				k_q <= k2p1;
				s_q <= IW'(mid + IW'(1));
			end
			razt_pkg::OP_LEFT_TAIL: begin
				k_q <= k2;
				e_q <= mid;
			end
			razt_pkg::OP_POP: begin
				k_q   <= stk_k_q[top];
				s_q   <= stk_s_q[top];
				e_q   <= stk_e_q[top];
				ret_q <= stk_r_q[top];
			end
			razt_pkg::OP_SET_RES: begin
				pos_q <= razt_pkg::POS_W'(s_q);
			end
			razt_pkg::OP_SET_NONE: begin
				pos_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// Control registers: size, clear sweep, stack depth, result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= razt_pkg::SIZE_RESET;
			clr_q       <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data[razt_pkg::SIZE_W-1:0];
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				razt_pkg::OP_CLR: clr_q <= clr_q + AW'(1);
				razt_pkg::OP_START: sp_q <= '0;
				razt_pkg::OP_PUSH_LEFT, razt_pkg::OP_PUSH_RIGHT: sp_q <= sp_q + PW'(1);
				razt_pkg::OP_POP: sp_q <= sp_q - PW'(1);
				razt_pkg::OP_SET_RES: begin
					out_valid_q <= 1'b1;
					found_q     <= 1'b1;
				end
				razt_pkg::OP_SET_NONE: begin
					out_valid_q <= 1'b1;
					found_q     <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Status back to the controller.
	always_comb begin
		stat.clr_last  = &clr_q;
		stat.is_find   = cmd_q;
		stat.full      = full;
		stat.disjoint  = disj;
		stat.leaf      = (s_q == e_q);
		stat.prune     = prune_q;
		stat.tnz       = (t_now != '0);
		stat.stk_empty = (sp_q == '0);
		stat.ret       = ret_q;
		stat.out_busy  = out_valid_q;
	end

	assign out_valid = out_valid_q;
	assign out_found = found_q;
	assign out_pos   = pos_q;

	`RAZT_ASSERT(a_stack_bound, (sp_q <= PW'(DEPTH)), "stack depth exceeded")
	`RAZT_ASSERT(a_push_room, ((cmd.op == razt_pkg::OP_PUSH_LEFT || cmd.op == razt_pkg::OP_PUSH_RIGHT) |-> (sp_q < PW'(DEPTH))), "push on full stack")
	`RAZT_ASSERT(a_pop_nonempty, ((cmd.op == razt_pkg::OP_POP) |-> (sp_q != '0)), "pop on empty stack")
	`RAZT_ASSERT_NEXT(a_result_shown, (cmd.op == razt_pkg::OP_SET_RES || cmd.op == razt_pkg::OP_SET_NONE), out_valid_q, "result not presented")

endmodule

// ----- design/razt_ctrl.sv -----
// ---------------------------------------------------------------------------
// razt_ctrl
// Controller: sequences the clearing sweep and the tree walk of each item,
// one datapath operation per cycle.
// ---------------------------------------------------------------------------
module razt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  razt_pkg::dp_stat_t stat,
	output razt_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VISIT_RD,
		ST_VISIT_WR,
		ST_LCH_RD,
		ST_LCH_WR,
		ST_RCH_RD,
		ST_RCH_WR,
		ST_DECIDE,
		ST_RETURN,
		ST_RESUME,
		ST_MRG_R,
		ST_MRG_WR,
		ST_FOUND,
		ST_NONE
	} state_t;

	state_t state_q, nxt;

	// Next state and the operation for this cycle.
	always_comb begin
		nxt = state_q;
		cmd = '{op: razt_pkg::OP_NONE, ret: razt_pkg::RET_ADD_L};
		case (state_q)
			ST_CLEAR: begin
				cmd.op = razt_pkg::OP_CLR;
				if (stat.clr_last) begin
					nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = razt_pkg::OP_START;
					nxt = ST_VISIT_RD;
				end
			end
			ST_VISIT_RD: begin
				cmd.op = razt_pkg::OP_RD_NODE;
				nxt = ST_VISIT_WR;
			end
			ST_VISIT_WR: begin
				cmd.op = razt_pkg::OP_WR_NODE;
				nxt = (stat.tnz && !stat.leaf) ? ST_LCH_RD : ST_DECIDE;
			end
			ST_LCH_RD: begin
				cmd.op = razt_pkg::OP_RD_LCH;
				nxt = ST_LCH_WR;
			end
			ST_LCH_WR: begin
				cmd.op = razt_pkg::OP_WR_LCH;
				nxt = ST_RCH_RD;
			end
			ST_RCH_RD: begin
				cmd.op = razt_pkg::OP_RD_RCH;
				nxt = ST_RCH_WR;
			end
			ST_RCH_WR: begin
				cmd.op = razt_pkg::OP_WR_RCH;
				nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.is_find) begin
					if (stat.prune) begin
						nxt = ST_RETURN;
					end else if (stat.leaf) begin
						nxt = ST_FOUND;
					end else begin
						cmd = '{op: razt_pkg::OP_PUSH_RIGHT, ret: razt_pkg::RET_FIND_R};
						nxt = ST_VISIT_RD;
					end
				end else if (stat.disjoint || stat.full || stat.leaf) begin
					nxt = ST_RETURN;
				end else begin
					cmd = '{op: razt_pkg::OP_PUSH_LEFT, ret: razt_pkg::RET_ADD_L};
					nxt = ST_VISIT_RD;
				end
			end
			ST_RETURN: begin
				if (stat.stk_empty) begin
					nxt = stat.is_find ? ST_NONE : ST_IDLE;
				end else begin
					cmd.op = razt_pkg::OP_POP;
					nxt = ST_RESUME;
				end
			end
			ST_RESUME: begin
				case (stat.ret)
					razt_pkg::RET_ADD_L: begin
						cmd = '{op: razt_pkg::OP_PUSH_RIGHT, ret: razt_pkg::RET_ADD_R};
						nxt = ST_VISIT_RD;
					end
					razt_pkg::RET_ADD_R: begin
						cmd.op = razt_pkg::OP_RD_LCH;
						nxt = ST_MRG_R;
					end
					razt_pkg::RET_FIND_R: begin
						cmd.op = razt_pkg::OP_LEFT_TAIL;
						nxt = ST_VISIT_RD;
					end
					default: begin
						nxt = ST_RETURN;
					end
				endcase
			end
			ST_MRG_R: begin
				cmd.op = razt_pkg::OP_RD_RCH;
				nxt = ST_MRG_WR;
			end
			ST_MRG_WR: begin
				cmd.op = razt_pkg::OP_MERGE;
				nxt = ST_RETURN;
			end
			ST_FOUND: begin
				if (!stat.out_busy) begin
					cmd.op = razt_pkg::OP_SET_RES;
					nxt = ST_IDLE;
				end
			end
			ST_NONE: begin
				if (!stat.out_busy) begin
					cmd.op = razt_pkg::OP_SET_NONE;
					nxt = ST_IDLE;
				end
			end
			default: begin
				nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= nxt;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

// ----- design/range_add_rightmost_zero_tree.sv -----
// ---------------------------------------------------------------------------
// range_add_rightmost_zero_tree
// Lazy tree of min/max/pending-add nodes: range add of a signed delta, and
// search for the rightmost zero position at or after a start position.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tuser: cmd; tdata: low, high, delta
// m_axis    out  m_axis_tvalid/tready       tuser: found; tdata: position
// cfg       in   cfg_valid/cfg_ready        cfg_data: size_in_use
//
// Each node visit reads the node, writes it back and decides; when a pending
// add is pushed to the children, each child is read and written back first.
// Every step back up pops the parent frame from the stack, and a merge of two
// children reads both and writes the parent. The single-port node memory sets
// this order. A find that prunes nothing ends at the last leaf. After reset a
// clearing sweep over all 4*LEAVES node entries (4096 by default) runs
// before the first item is taken. One item is worked at a time; a finished
// find result waits in its output register while the next item is taken.
// The size register is written only while the sequencer is idle and no
// input item is offered.
// ---------------------------------------------------------------------------
module range_add_rightmost_zero_tree #(
	parameter int unsigned LEAVES = razt_pkg::LEAVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // range_low[9:0], range_high[19:10], delta[31:20]
	input  logic        s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // position[9:0], zero fill
	output logic        m_axis_tuser,   // found
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data        // size_in_use[10:0], zero fill
);

	razt_pkg::dp_cmd_t  cmd;
	razt_pkg::dp_stat_t stat;
	logic [razt_pkg::POS_W-1:0] pos;

	// Sequencer.
	razt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Node memory, stack and result.
	razt_dp #(
		.LEAVES (LEAVES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_cmd    (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_found (m_axis_tuser),
		.out_pos   (pos)
	);

	// The size is taken only between items, never beside a new input item.
	assign cfg_ready    = s_axis_tready && !s_axis_tvalid;
	assign m_axis_tdata = 16'(pos);

endmodule
